### rtl/core/ccl_pkg.sv
// Shared types, constants and helpers for the cheat code list parser.
`default_nettype none
package ccl_pkg;

   // field digit limits
   localparam int ADDRESS_DIGITS = 8;
   localparam int VALUE_DIGITS   = 2;

   // character counters saturate here
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] COUNT_MAX  = CNT_W'(9);
   localparam logic [CNT_W-1:0] ADDR_LIMIT = CNT_W'(ADDRESS_DIGITS);
   localparam logic [CNT_W-1:0] VAL_LIMIT  = CNT_W'(VALUE_DIGITS);

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // separator characters
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_SEMI  = 8'h3b;

   // hex digit offsets
   localparam logic [7:0] LOWER_HEX_OFS = 8'h57;
   localparam logic [7:0] UPPER_HEX_OFS = 8'h37;
   localparam logic [4:0] NOT_HEX       = 5'd16;

   typedef struct packed {
      logic                 in_addr;
      logic                 collecting;
      logic [31:0]          addr_acc;
      logic [CNT_W-1:0]     addr_cnt;
      logic [7:0]           val_acc;
      logic [CNT_W-1:0]     val_cnt;
      logic [31:0]          offset;
   } parse_state_type;

   typedef struct packed {
      logic [31:0] address;
      logic [7:0]  value;
      logic        closing;
   } entry_type;

   localparam parse_state_type STATE_RESET = '{
      in_addr:    1'b1,
      collecting: 1'b0,
      addr_acc:   32'd0,
      addr_cnt:   '0,
      val_acc:    8'd0,
      val_cnt:    '0,
      offset:     32'd0
   };

   // digit value, or NOT_HEX
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd16;
         if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
         end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - LOWER_HEX_OFS;
         end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - UPPER_HEX_OFS;
         end
         return d[4:0];
      end
   endfunction

   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] n);
      return (n < COUNT_MAX) ? n + CNT_W'(1) : COUNT_MAX;
   endfunction

   function automatic entry_type make_entry(input parse_state_type s, input logic closing);
      entry_type e;
      logic [31:0] a;
      begin
         a         = (s.addr_cnt > ADDR_LIMIT) ? 32'd0 : s.addr_acc;
         e.address = a + s.offset;
         e.value   = (s.val_cnt > VAL_LIMIT) ? 8'd0 : s.val_acc;
         e.closing = closing;
         return e;
      end
   endfunction

endpackage
`default_nettype wire

### rtl/core/cheat_code_list_parser.sv
// Top level of the cheat code list parser: parse state and result queue.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | character, end_of_string
//  rsp     | out       | rsp_valid/rsp_stall  | entry_address, entry_value, closing_entry
//
// One character word is taken per cycle while req_stall is low; its parse
// step is done in the cycle it is accepted and its entries (zero, one or
// two) land in a four-word queue whose head drives the rsp ports. The rsp
// side drains one word per cycle while rsp_stall is low. req_stall rises
// when fewer than two queue slots are free. Reset (synchronous) returns the
// parse state to address mode and empties the queue.
`default_nettype none
module cheat_code_list_parser
   import ccl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_entry_address,
   output logic [7:0]  rsp_entry_value,
   output logic        rsp_closing_entry
);

   parse_state_type   state_ff, state_in;
   parse_state_type   state_step;
   logic [1:0]        emit_cnt;
   entry_type         ent0, ent1;
   entry_type         head;
   logic [QCNT_W-1:0] q_count;
   logic              req_take;
   logic              rsp_take;

   // room for a worst-case pair of entries
   assign req_stall = (q_count > QCNT_W'(QUEUE_DEPTH - 2));
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (q_count != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;

   ccl_parse u_parse (
      .st       (state_ff),
      .char_in  (req_character),
      .last     (req_end_of_string),
      .nxt      (state_step),
      .emit_cnt (emit_cnt),
      .ent0     (ent0),
      .ent1     (ent1)
   );

   // state moves only on an accepted word
   assign state_in = req_take ? state_step : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   ccl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (req_take ? emit_cnt : 2'd0),
      .push0    (ent0),
      .push1    (ent1),
      .pop      (rsp_take),
      .head     (head),
      .count    (q_count)
   );

   assign rsp_entry_address = head.address;
   assign rsp_entry_value   = head.value;
   assign rsp_closing_entry = head.closing;

endmodule
`default_nettype wire

### rtl/core/ccl_parse.sv
// Per-character parse step: next state and up to two emitted entries.
`default_nettype none
module ccl_parse
   import ccl_pkg::*;
(
   input  parse_state_type st,
   input  logic [7:0]      char_in,
   input  logic            last,
   output parse_state_type nxt,
   output logic [1:0]      emit_cnt,
   output entry_type       ent0,
   output entry_type       ent1
);

   parse_state_type mid;
   logic            emit_mid;
   entry_type       ent_mid;
   entry_type       ent_close;
   logic [4:0]      dig;

   always_comb begin
      mid      = st;
      emit_mid = 1'b0;
      ent_mid  = make_entry(st, 1'b0);
      dig      = hex_digit(char_in);

      unique case (char_in)
         CHAR_SPACE: begin
         end
         CHAR_COMMA: begin
            if (st.in_addr) begin
               mid.in_addr = 1'b0;
            end else begin
               emit_mid   = 1'b1;
               mid.offset = st.offset + 32'd1;
            end
            mid.val_acc    = 8'd0;
            mid.val_cnt    = '0;
            mid.collecting = 1'b1;
         end
         CHAR_SEMI: begin
            emit_mid       = 1'b1;
            mid.in_addr    = 1'b1;
            mid.collecting = 1'b0;
            mid.addr_acc   = 32'd0;
            mid.addr_cnt   = '0;
            mid.offset     = 32'd0;
         end
         default: begin
            if (st.collecting) begin
               if (dig != NOT_HEX) mid.val_acc = {st.val_acc[3:0], dig[3:0]};
               mid.val_cnt = count_up(st.val_cnt);
            end else begin
               if (dig != NOT_HEX) mid.addr_acc = {st.addr_acc[27:0], dig[3:0]};
               mid.addr_cnt = count_up(st.addr_cnt);
            end
         end
      endcase

      // closing entry sees the state after this character
      ent_close = make_entry(mid, 1'b1);
      nxt       = mid;
      if (last) begin
         nxt.in_addr    = 1'b1;
         nxt.collecting = 1'b0;
         nxt.addr_acc   = 32'd0;
         nxt.addr_cnt   = '0;
         nxt.offset     = 32'd0;
      end

      emit_cnt = 2'(emit_mid) + 2'(last);
      ent0     = emit_mid ? ent_mid : ent_close;
      ent1     = ent_close;
   end

endmodule
`default_nettype wire

### rtl/core/ccl_queue.sv
// Small result queue: pushes up to two entries per cycle, pops one.
`default_nettype none
module ccl_queue
   import ccl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_cnt,
   input  entry_type         push0,
   input  entry_type         push1,
   input  logic              pop,
   output entry_type         head,
   output logic [QCNT_W-1:0] count
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wr_ptr_nx;

   assign wr_ptr_nx = wr_ptr_ff + QPTR_W'(1);
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push_cnt) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) mem_ff[wr_ptr_ff] <= push0;
      if (push_cnt == 2'd2) mem_ff[wr_ptr_nx] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/ccl_checker.sv
// Port-level checks for the cheat code list parser, bound to the top level.
`default_nettype none
module ccl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_end_of_string,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_entry_address,
   input logic [7:0]  rsp_entry_value,
   input logic        rsp_closing_entry
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_entry_address)
                                 && $stable(rsp_entry_value) && $stable(rsp_closing_entry))
      else $error("rsp word changed while stalled");

   // end of string always yields a closing entry
   a_close_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_string |=> rsp_valid)
      else $error("no entry after end of string");

   // empty and ready after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // input never blocked while output is empty
   a_stall_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty queue");

endmodule

bind cheat_code_list_parser ccl_checker u_ccl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_end_of_string (req_end_of_string),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_entry_address (rsp_entry_address),
   .rsp_entry_value   (rsp_entry_value),
   .rsp_closing_entry (rsp_closing_entry)
);
`default_nettype wire
